/* src/brace_matcher_skip_strings_comments_top_assert.svh */
// assertion macros for the brace matcher checker
`ifndef BRACE_MATCHER_SKIP_STRINGS_COMMENTS_TOP_ASSERT_SVH
`define BRACE_MATCHER_SKIP_STRINGS_COMMENTS_TOP_ASSERT_SVH

// clocked assertion, off while reset is low
`define BMSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked during reset as well
`define BMSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/bmsc_pkg.sv */
// shared types and constants for the brace matcher
`timescale 1ns / 1ps

package bmsc_pkg;

    localparam int DEPTH_W = 16;
    localparam int LEVEL_W = 16;
    localparam int BYTE_W  = 8;
    localparam int SAT_W   = (DEPTH_W > LEVEL_W) ? DEPTH_W : LEVEL_W;

    localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_DQUOTE    = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE    = 8'h27;
    localparam logic [BYTE_W-1:0] CH_BACKTICK  = 8'h60;
    localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR      = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;

    typedef enum logic [2:0] {
        MODE_CODE  = 3'd0,
        MODE_DQ    = 3'd1,
        MODE_SQ    = 3'd2,
        MODE_BT    = 3'd3,
        MODE_LINE  = 3'd4,
        MODE_BLOCK = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_SCAN      = 3'd1,
        ST_MATCH     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_START = 3'd4
    } t_status;

    typedef logic [DEPTH_W-1:0] t_depth;
    typedef logic [LEVEL_W-1:0] t_level;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              start_mark;
        logic              end_mark;
    } t_item;

    typedef struct packed {
        t_status status;
        t_level  level;
    } t_result;

    // depth as shown on the port, held at all ones if it does not fit
    function automatic t_level f_show_level(input t_depth d);
        logic [SAT_W-1:0] wide;
        wide = SAT_W'(d);
        if (wide > SAT_W'({LEVEL_W{1'b1}})) begin
            return {LEVEL_W{1'b1}};
        end else begin
            return wide[LEVEL_W-1:0];
        end
    endfunction

endpackage

/* src/bmsc_if.sv */
// valid/ready channels for text bytes and scan results
`timescale 1ns / 1ps

interface bmsc_in_if;
    logic                              valid;
    logic                              ready;
    logic [bmsc_pkg::BYTE_W-1:0]       text_byte;
    logic                              start_mark;
    logic                              end_mark;

    modport source (output valid, output text_byte, output start_mark, output end_mark,
                    input ready);
    modport sink   (input valid, input text_byte, input start_mark, input end_mark,
                    output ready);
endinterface

interface bmsc_out_if;
    logic                  valid;
    logic                  ready;
    bmsc_pkg::t_status     status;
    bmsc_pkg::t_level      level;

    modport source (output valid, output status, output level, input ready);
    modport sink   (input valid, input status, input level, output ready);
endinterface

/* src/bmsc_in_reg.sv */
// input register for one text byte and its marks
`timescale 1ns / 1ps

module bmsc_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bmsc_pkg::t_item i_item,
    input  logic            i_take,
    output logic            o_valid,
    output bmsc_pkg::t_item o_item
);

    logic            r_valid;
    logic            n_valid;
    bmsc_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* src/bmsc_scan.sv */
// lexical scanner state and per-byte update
`timescale 1ns / 1ps

module bmsc_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  bmsc_pkg::t_item   i_item,
    output bmsc_pkg::t_result o_result
);

    bmsc_pkg::t_mode                 r_mode;
    bmsc_pkg::t_mode                 n_mode;
    bmsc_pkg::t_depth                r_depth;
    bmsc_pkg::t_depth                n_depth;
    logic [bmsc_pkg::BYTE_W-1:0]     r_prev;
    logic                            r_slash;
    logic                            n_slash;
    logic                            r_active;
    logic                            n_active;

    logic [bmsc_pkg::BYTE_W-1:0]     w_c;
    logic                            w_esc;
    logic                            w_code;
    logic                            w_match;
    bmsc_pkg::t_depth                w_dec;

    assign w_c   = i_item.text_byte;
    assign w_esc = (r_prev == bmsc_pkg::CH_BACKSLASH);
    assign w_dec = (r_depth != '0) ? (r_depth - bmsc_pkg::DEPTH_W'(1)) : r_depth;

    always_comb begin
        n_mode   = r_mode;
        n_depth  = r_depth;
        n_slash  = r_slash;
        n_active = r_active;
        w_code   = 1'b0;
        w_match  = 1'b0;
        o_result.status = bmsc_pkg::ST_IDLE;
        o_result.level  = '0;

        if (i_item.start_mark) begin
            n_mode  = bmsc_pkg::MODE_CODE;
            n_slash = 1'b0;
            if (w_c != bmsc_pkg::CH_LBRACE) begin
                n_active        = 1'b0;
                n_depth         = '0;
                o_result.status = bmsc_pkg::ST_BAD_START;
            end else begin
                n_depth         = bmsc_pkg::DEPTH_W'(1);
                n_active        = !i_item.end_mark;
                o_result.status = i_item.end_mark ? bmsc_pkg::ST_NOT_FOUND
                                                  : bmsc_pkg::ST_SCAN;
                o_result.level  = bmsc_pkg::f_show_level(n_depth);
            end
        end else if (r_active) begin
            case (r_mode)
                bmsc_pkg::MODE_DQ: begin
                    if (w_c == bmsc_pkg::CH_DQUOTE && !w_esc) n_mode = bmsc_pkg::MODE_CODE;
                end
                bmsc_pkg::MODE_SQ: begin
                    if (w_c == bmsc_pkg::CH_SQUOTE && !w_esc) n_mode = bmsc_pkg::MODE_CODE;
                end
                bmsc_pkg::MODE_BT: begin
                    if (w_c == bmsc_pkg::CH_BACKTICK && !w_esc) n_mode = bmsc_pkg::MODE_CODE;
                end
                bmsc_pkg::MODE_LINE: begin
                    if (w_c == bmsc_pkg::CH_NEWLINE) n_mode = bmsc_pkg::MODE_CODE;
                end
                bmsc_pkg::MODE_BLOCK: begin
                    if (w_c == bmsc_pkg::CH_SLASH && r_prev == bmsc_pkg::CH_STAR) begin
                        n_mode = bmsc_pkg::MODE_CODE;
                    end
                end
                default: begin
                    w_code = 1'b1;
                    if (r_slash) begin
                        n_slash = 1'b0;
                        if (w_c == bmsc_pkg::CH_SLASH) begin
                            n_mode = bmsc_pkg::MODE_LINE;
                            w_code = 1'b0;
                        end else if (w_c == bmsc_pkg::CH_STAR) begin
                            n_mode = bmsc_pkg::MODE_BLOCK;
                            w_code = 1'b0;
                        end
                    end
                end
            endcase

            if (w_code) begin
                if (w_c == bmsc_pkg::CH_LBRACE) begin
                    if (r_depth != '1) n_depth = r_depth + bmsc_pkg::DEPTH_W'(1);
                end else if (w_c == bmsc_pkg::CH_RBRACE) begin
                    n_depth = w_dec;
                    w_match = (w_dec == '0);
                end else if (w_c == bmsc_pkg::CH_DQUOTE) begin
                    n_mode = bmsc_pkg::MODE_DQ;
                end else if (w_c == bmsc_pkg::CH_SQUOTE) begin
                    n_mode = bmsc_pkg::MODE_SQ;
                end else if (w_c == bmsc_pkg::CH_BACKTICK) begin
                    n_mode = bmsc_pkg::MODE_BT;
                end else if (w_c == bmsc_pkg::CH_SLASH) begin
                    n_slash = 1'b1;
                end
            end

            if (w_match) begin
                n_active        = 1'b0;
                o_result.status = bmsc_pkg::ST_MATCH;
            end else begin
                o_result.level = bmsc_pkg::f_show_level(n_depth);
                if (i_item.end_mark) begin
                    n_active        = 1'b0;
                    o_result.status = bmsc_pkg::ST_NOT_FOUND;
                end else begin
                    o_result.status = bmsc_pkg::ST_SCAN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= bmsc_pkg::MODE_CODE;
            r_depth  <= '0;
            r_prev   <= '0;
            r_slash  <= 1'b0;
            r_active <= 1'b0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_depth  <= n_depth;
            r_prev   <= w_c;
            r_slash  <= n_slash;
            r_active <= n_active;
        end
    end

endmodule

/* src/bmsc_out_reg.sv */
// result register for one status beat
`timescale 1ns / 1ps

module bmsc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  bmsc_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output bmsc_pkg::t_result o_result
);

    logic              r_valid;
    logic              n_valid;
    bmsc_pkg::t_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* src/brace_matcher_skip_strings_comments_top.sv */
// Matching-brace finder that skips strings and comments, one byte per beat.
// A beat with start_mark opens a search on '{'; each beat gives one result beat
// with status and the nesting level. Throughput is one byte per clock while the
// result side is ready: the scanner state (mode, depth, previous byte, pending
// slash, active flag) updates as the byte moves from the input register into the
// result register, where its result beat is then valid. Backpressure on the result
// side stalls the input side through the two registers without losing beats.
`timescale 1ns / 1ps

module brace_matcher_skip_strings_comments_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bmsc_in_if.sink           i_in,
    bmsc_out_if.source        o_out
);

    bmsc_pkg::t_item   w_in_item;
    bmsc_pkg::t_item   w_item;
    bmsc_pkg::t_result w_result;
    bmsc_pkg::t_result w_out_result;
    logic              w_item_valid;
    logic              w_out_free;
    logic              w_step;

    assign w_in_item.text_byte  = i_in.text_byte;
    assign w_in_item.start_mark = i_in.start_mark;
    assign w_in_item.end_mark   = i_in.end_mark;

    assign w_step = w_item_valid && w_out_free;

    bmsc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (w_in_item),
        .i_take  (w_step),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    bmsc_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (w_item),
        .o_result (w_result)
    );

    bmsc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_step),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (w_out_result)
    );

    assign o_out.status = w_out_result.status;
    assign o_out.level  = w_out_result.level;

endmodule

/* src/bmsc_checker.sv */
// port checks for the brace matcher and their bind
`timescale 1ns / 1ps
`include "brace_matcher_skip_strings_comments_top_assert.svh"

module bmsc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input bmsc_pkg::t_status i_out_status,
    input bmsc_pkg::t_level  i_out_level
);

    // stalled result beat holds
    `BMSC_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_status) && $stable(i_out_level)), "result beat changed while stalled")

    // only defined status codes leave the block
    `BMSC_ASSERT(a_status_code, i_clk, i_rst_n, i_out_valid |-> (i_out_status == bmsc_pkg::ST_IDLE || i_out_status == bmsc_pkg::ST_SCAN || i_out_status == bmsc_pkg::ST_MATCH || i_out_status == bmsc_pkg::ST_NOT_FOUND || i_out_status == bmsc_pkg::ST_BAD_START), "undefined status code")

    // idle, match and bad start report zero level
    `BMSC_ASSERT(a_zero_level, i_clk, i_rst_n, (i_out_valid && (i_out_status == bmsc_pkg::ST_IDLE || i_out_status == bmsc_pkg::ST_MATCH || i_out_status == bmsc_pkg::ST_BAD_START)) |-> (i_out_level == '0), "nonzero level on a closed search")

    // an open search is always at least one level deep
    `BMSC_ASSERT(a_scan_level, i_clk, i_rst_n, (i_out_valid && i_out_status == bmsc_pkg::ST_SCAN) |-> (i_out_level != '0), "scanning with zero level")

endmodule

bind brace_matcher_skip_strings_comments_top bmsc_checker u_bmsc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_level  (o_out.level)
);

/* dv/tb_brace_matcher_skip_strings_comments_top.sv */
// testbench for the brace matcher: directed and random text beats checked against a scanner predictor
`timescale 1ns / 1ps

module tb_brace_matcher_skip_strings_comments_top;
    import bmsc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DEEP_BRACES   = 40;
    localparam int MAX_REPORTS   = 10;

    logic clk;
    logic rst_n;

    bmsc_in_if  in_if ();
    bmsc_out_if out_if ();

    brace_matcher_skip_strings_comments_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // scanner state as predicted
    t_mode            sc_mode;
    t_depth           sc_depth;
    logic [BYTE_W-1:0] sc_prev;
    logic             sc_slash;
    logic             sc_active;

    t_result scan_reports_q[$];
    int      status_tally[5];
    int      active_beats;
    int      total_beats;
    int      errors;
    int      cycle_count;
    int      stall_left;
    int      top_level;
    bit      idle_on;

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, scan_reports_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side stalls in short bursts
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    task automatic note_error(input string what);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%s", what);
        end
    endtask

    always @(posedge clk) begin : check_results
        t_result exp_r;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (scan_reports_q.size() == 0) begin
                note_error($sformatf("unexpected result beat: status %0d level %0d",
                                     out_if.status, out_if.level));
            end else begin
                exp_r = scan_reports_q.pop_front();
                if (out_if.status !== exp_r.status || out_if.level !== exp_r.level) begin
                    note_error($sformatf("mismatch: expected status %0d level %0d, got status %0d level %0d",
                                         exp_r.status, exp_r.level, out_if.status, out_if.level));
                end
            end
        end
    end

    function automatic t_result advance_scanner(input t_item it);
        t_result           r;
        logic [BYTE_W-1:0] c;
        logic              esc;
        logic              matched;
        c       = it.text_byte;
        esc     = (sc_prev == CH_BACKSLASH);
        matched = 1'b0;
        r.level = '0;
        if (it.start_mark) begin
            sc_mode  = MODE_CODE;
            sc_slash = 1'b0;
            if (c != CH_LBRACE) begin
                sc_active = 1'b0;
                sc_depth  = '0;
                r.status  = ST_BAD_START;
            end else begin
                sc_depth  = t_depth'(1);
                sc_active = !it.end_mark;
                r.status  = it.end_mark ? ST_NOT_FOUND : ST_SCAN;
                r.level   = sc_depth;
            end
        end else if (!sc_active) begin
            r.status = ST_IDLE;
        end else begin
            case (sc_mode)
                MODE_DQ: if (c == CH_DQUOTE && !esc) sc_mode = MODE_CODE;
                MODE_SQ: if (c == CH_SQUOTE && !esc) sc_mode = MODE_CODE;
                MODE_BT: if (c == CH_BACKTICK && !esc) sc_mode = MODE_CODE;
                MODE_LINE: if (c == CH_NEWLINE) sc_mode = MODE_CODE;
                MODE_BLOCK: if (c == CH_SLASH && sc_prev == CH_STAR) sc_mode = MODE_CODE;
                default: begin
                    if (sc_slash && c == CH_SLASH) begin
                        sc_slash = 1'b0;
                        sc_mode  = MODE_LINE;
                    end else if (sc_slash && c == CH_STAR) begin
                        sc_slash = 1'b0;
                        sc_mode  = MODE_BLOCK;
                    end else begin
                        sc_slash = 1'b0;
                        if (c == CH_LBRACE) begin
                            if (sc_depth != '1) sc_depth = sc_depth + t_depth'(1);
                        end else if (c == CH_RBRACE) begin
                            if (sc_depth != '0) sc_depth = sc_depth - t_depth'(1);
                            matched = (sc_depth == '0);
                        end else if (c == CH_DQUOTE) begin
                            sc_mode = MODE_DQ;
                        end else if (c == CH_SQUOTE) begin
                            sc_mode = MODE_SQ;
                        end else if (c == CH_BACKTICK) begin
                            sc_mode = MODE_BT;
                        end else if (c == CH_SLASH) begin
                            sc_slash = 1'b1;
                        end
                    end
                end
            endcase
            if (matched) begin
                sc_active = 1'b0;
                r.status  = ST_MATCH;
            end else begin
                r.level = sc_depth;
                if (it.end_mark) begin
                    sc_active = 1'b0;
                    r.status  = ST_NOT_FOUND;
                end else begin
                    r.status = ST_SCAN;
                end
            end
        end
        sc_prev = c;
        return r;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] c, input bit s, input bit e);
        t_item   it;
        t_result r;
        int      gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge clk);
                in_if.valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_if.valid      <= 1'b1;
        in_if.text_byte  <= c;
        in_if.start_mark <= s;
        in_if.end_mark   <= e;
        do @(posedge clk); while (!in_if.ready);
        it = '{text_byte: c, start_mark: s, end_mark: e};
        r  = advance_scanner(it);
        scan_reports_q.push_back(r);
        status_tally[int'(r.status)]++;
        total_beats++;
        if (r.status != ST_IDLE) active_beats++;
        if (int'(r.level) > top_level) top_level = int'(r.level);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (scan_reports_q.size() != 0) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_text_char();
        case ($urandom_range(0, 19))
            0, 1, 2:    return CH_LBRACE;
            3, 4, 5:    return CH_RBRACE;
            6:          return CH_DQUOTE;
            7:          return CH_SQUOTE;
            8:          return CH_BACKTICK;
            9, 10:      return CH_SLASH;
            11:         return CH_STAR;
            12:         return CH_BACKSLASH;
            13:         return CH_NEWLINE;
            14, 15, 16: return 8'(8'h61 + $urandom_range(0, 25));
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_idle_and_restart();
        send_byte(8'hFF, 1'b0, 1'b1);       // idle, end mark ignored
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h41, 1'b1, 1'b0);       // bad start
        send_byte(CH_LBRACE, 1'b1, 1'b1);   // start on last byte
        send_byte(CH_LBRACE, 1'b1, 1'b0);
        send_byte(CH_LBRACE, 1'b0, 1'b0);
        send_byte(CH_LBRACE, 1'b1, 1'b0);   // restart aborts running search
        send_byte(CH_RBRACE, 1'b0, 1'b0);
    endtask

    task automatic test_strings();
        send_byte(CH_LBRACE, 1'b1, 1'b0);
        send_byte(CH_DQUOTE, 1'b0, 1'b0);
        send_byte(CH_RBRACE, 1'b0, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0, 1'b0);
        send_byte(CH_DQUOTE, 1'b0, 1'b0);   // escaped quote
        send_byte(CH_DQUOTE, 1'b0, 1'b0);
        send_byte(CH_SQUOTE, 1'b0, 1'b0);
        send_byte(CH_SQUOTE, 1'b0, 1'b0);
        send_byte(CH_BACKTICK, 1'b0, 1'b0);
        send_byte(CH_RBRACE, 1'b0, 1'b0);
        send_byte(CH_BACKTICK, 1'b0, 1'b0);
        send_byte(CH_RBRACE, 1'b0, 1'b0);
    endtask

    task automatic test_comments();
        send_byte(CH_LBRACE, 1'b1, 1'b0);
        send_byte(CH_SLASH, 1'b0, 1'b0);
        send_byte(CH_SLASH, 1'b0, 1'b0);    // line comment
        send_byte(CH_RBRACE, 1'b0, 1'b0);
        send_byte(CH_NEWLINE, 1'b0, 1'b0);
        send_byte(CH_SLASH, 1'b0, 1'b0);
        send_byte(CH_STAR, 1'b0, 1'b0);     // block comment
        send_byte(CH_RBRACE, 1'b0, 1'b0);
        send_byte(CH_STAR, 1'b0, 1'b0);
        send_byte(CH_SLASH, 1'b0, 1'b0);
        send_byte(CH_SLASH, 1'b0, 1'b0);    // lone slash, then code
        send_byte(CH_LBRACE, 1'b0, 1'b0);
        send_byte(CH_RBRACE, 1'b0, 1'b0);
        send_byte(8'h78, 1'b0, 1'b1);       // text ends unmatched
    endtask

    task automatic test_random(input int target);
        int first;
        int len;
        bit e;
        first = active_beats;
        while (active_beats - first < target) begin
            case ($urandom_range(0, 9))
                0: send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
                1: send_byte(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
                default: begin
                    e = ($urandom_range(0, 19) == 0);
                    send_byte(CH_LBRACE, 1'b1, e);
                    len = $urandom_range(0, 30);
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(0, 59) == 0) begin
                            send_byte(CH_LBRACE, 1'b1, 1'b0);
                        end else if (i == len - 1) begin
                            send_byte(pick_text_char(), 1'b0, 1'($urandom_range(0, 1)));
                        end else begin
                            send_byte(pick_text_char(), 1'b0, ($urandom_range(0, 39) == 0));
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic test_deep_nesting();
        send_byte(CH_LBRACE, 1'b1, 1'b0);
        for (int i = 0; i < DEEP_BRACES; i++) begin
            send_byte(CH_LBRACE, 1'b0, 1'b0);
        end
        send_byte(CH_RBRACE, 1'b0, 1'b0);
        send_byte(8'h61, 1'b0, 1'b1);
    endtask

    initial begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.text_byte  = '0;
        in_if.start_mark = 1'b0;
        in_if.end_mark   = 1'b0;
        out_if.ready     = 1'b1;
        stall_left       = 0;
        cycle_count      = 0;
        errors           = 0;
        active_beats     = 0;
        total_beats      = 0;
        top_level        = 0;
        idle_on          = 1'b1;
        sc_mode          = MODE_CODE;
        sc_depth         = '0;
        sc_prev          = '0;
        sc_slash         = 1'b0;
        sc_active        = 1'b0;
        foreach (status_tally[k]) status_tally[k] = 0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_idle_and_restart();
        wait_for_results();
        test_strings();
        wait_for_results();
        test_comments();
        wait_for_results();
        test_random(1200);
        wait_for_results();

        // last part runs without idling on either side
        idle_on = 1'b0;
        test_random(350);
        test_deep_nesting();
        wait_for_results();
        repeat (10) @(posedge clk);

        $display("%0d beats: %0d idle, %0d scanning, %0d matched, %0d not found, %0d bad start",
                 total_beats, status_tally[ST_IDLE], status_tally[ST_SCAN],
                 status_tally[ST_MATCH], status_tally[ST_NOT_FOUND], status_tally[ST_BAD_START]);
        $display("strings, comments, restarts and depth up to %0d exercised, %0d mismatches",
                 top_level, errors);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* brace_matcher_skip_strings_comments_top.f */
+incdir+src
src/bmsc_pkg.sv
src/bmsc_if.sv
src/bmsc_in_reg.sv
src/bmsc_scan.sv
src/bmsc_out_reg.sv
src/brace_matcher_skip_strings_comments_top.sv
src/bmsc_checker.sv
dv/tb_brace_matcher_skip_strings_comments_top.sv
